@@ sv/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// olist_pkg: shared types and codes for the ordered list engine
// request function codes, result status codes, cell update kinds and the
// control bundle broadcast from the sequencer to the cell row
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;
  localparam int KIND_W   = 3;

  // request function codes
  localparam logic [FUNC_W-1:0] FN_PREPEND    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_AFTER  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // cell update kinds
  localparam logic [KIND_W-1:0] KD_NONE       = 3'd0;
  localparam logic [KIND_W-1:0] KD_PREPEND    = 3'd1;
  localparam logic [KIND_W-1:0] KD_APPEND     = 3'd2;
  localparam logic [KIND_W-1:0] KD_INS_AFTER  = 3'd3;
  localparam logic [KIND_W-1:0] KD_INS_BEFORE = 3'd4;
  localparam logic [KIND_W-1:0] KD_DELETE     = 3'd5;

  typedef struct packed {
    logic              load;   // compare all entries against the operand
    logic              scan;   // move the match-before flags one cell on
    logic              apply;  // perform the update of the given kind
    logic [KIND_W-1:0] kind;
  } cell_ctrl_t;

endpackage

@@ sv/ordered_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_core: ordered list of signed 32-bit values
// a row of cells holds the list head first; requests prepend, append,
// insert at a key, delete or search, each giving one status and count
// ----------------------------------------------------------------------------
// usage:
//   request channel in_*: in_tuser carries the function code, in_tdata the
//   key and value. result channel out_*: out_tuser carries the status,
//   out_tdata the entry count after the request.
//   prepend, append and unused codes go from acceptance straight to the
//   apply step, which writes the result register. key and value requests
//   (insert after, insert before, delete, search) pass through the scan
//   state first: all cells compare at the accept edge, then the first-match
//   flag ripples one cell per cycle down the row, then the apply step
//   performs the update. one request is worked on at a time. a new request
//   is taken while the previous result still waits in the output register;
//   if the receiver stalls, the finished request holds in its apply step
//   until the output register frees.
//   reset empties the list (valid bits and count cleared) and drops any
//   pending result; entry contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key [31:0], value [63:32]
  input  logic [2:0]  in_tuser,   // func [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // entry_count [4:0], zero [7:5]
  output logic [1:0]  out_tuser   // status [1:0]
);
  import olist_pkg::*;

  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int STEP_W  = $clog2(CAPACITY);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [DATA_W-1:0]   value_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ECOUNT_W-1:0] ecount_r, ecount_nxt;

  logic                accept;
  logic                fire;
  logic                full;
  logic                found;
  logic [FUNC_W-1:0]   in_func;
  logic [DATA_W-1:0]   in_key;
  logic [DATA_W-1:0]   in_value;
  logic [DATA_W-1:0]   operand;
  logic [KIND_W-1:0]   kind;
  logic [STATUS_W-1:0] status_calc;
  logic [31:0]         count_ext;
  cell_ctrl_t          ctrl;

  // cell row wiring
  logic [DATA_W-1:0] entry_w [CAPACITY];
  logic              valid_w [CAPACITY];
  logic              pre_w   [CAPACITY];
  logic              hit_w   [CAPACITY];

  assign in_func  = in_tuser[FUNC_W-1:0];
  assign in_key   = in_tdata[DATA_W-1:0];
  assign in_value = in_tdata[2*DATA_W-1:DATA_W];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  // result register can take a new result when empty or being drained
  assign fire      = (state_r == S_APPLY) & (~out_valid_r | out_tready);

  assign full  = (count_r == COUNT_W'(CAPACITY));
  // the last cell's outgoing flag says a match exists anywhere in the row
  assign found = pre_w[CAPACITY-1];

  // anchor operand: key for inserts at a key, value for delete and search
  assign operand = ((in_func == FN_INS_AFTER) || (in_func == FN_INS_BEFORE)) ?
                   in_key : in_value;

  // decide what the apply step does and what it reports
  always_comb begin
    kind        = KD_NONE;
    status_calc = ST_MISSING;
    priority if ((func_r == FN_PREPEND || func_r == FN_APPEND ||
                  func_r == FN_INS_AFTER || func_r == FN_INS_BEFORE) && full) begin
      status_calc = ST_FULL;
    end else if (func_r == FN_PREPEND) begin
      kind        = KD_PREPEND;
      status_calc = ST_DONE;
    end else if (func_r == FN_APPEND) begin
      kind        = KD_APPEND;
      status_calc = ST_DONE;
    end else if (func_r == FN_INS_AFTER && found) begin
      kind        = KD_INS_AFTER;
      status_calc = ST_DONE;
    end else if (func_r == FN_INS_BEFORE && found) begin
      kind        = KD_INS_BEFORE;
      status_calc = ST_DONE;
    end else if (func_r == FN_DELETE && found) begin
      kind        = KD_DELETE;
      status_calc = ST_DONE;
    end else if (func_r == FN_SEARCH && found) begin
      status_calc = ST_DONE;
    end
  end

  always_comb begin
    ctrl.load  = accept;
    ctrl.scan  = (state_r == S_SCAN);
    ctrl.apply = fire;
    ctrl.kind  = kind;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          step_nxt = '0;
          // only key and value requests need the match flags to settle
          if (in_func == FN_INS_AFTER || in_func == FN_INS_BEFORE ||
              in_func == FN_DELETE || in_func == FN_SEARCH) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_SCAN: begin
        if (step_r == STEP_W'(CAPACITY - 2)) begin
          state_nxt = S_APPLY;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_APPLY: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // entry count and result register
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    status_nxt    = status_r;
    ecount_nxt    = ecount_r;
    if (fire) begin
      if (kind == KD_PREPEND || kind == KD_APPEND ||
          kind == KD_INS_AFTER || kind == KD_INS_BEFORE) begin
        count_nxt = count_r + COUNT_W'(1);
      end else if (kind == KD_DELETE) begin
        count_nxt = count_r - COUNT_W'(1);
      end
      out_valid_nxt = 1'b1;
      status_nxt    = status_calc;
      ecount_nxt    = count_ext[ECOUNT_W-1:0];
    end
  end

  // count reported modulo 32
  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      value_r <= in_value;
    end
    status_r <= status_nxt;
    ecount_r <= ecount_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_entry, next_entry;
    logic              prev_valid, prev_pre, prev_hit, next_valid;

    if (i == 0) begin : g_head
      // the head sees the new value as its left neighbor
      assign prev_entry = value_r;
      assign prev_valid = 1'b1;
      assign prev_pre   = 1'b0;
      assign prev_hit   = 1'b0;
    end else begin : g_mid
      assign prev_entry = entry_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_pre   = pre_w[i-1];
      assign prev_hit   = hit_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_entry = entry_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    olist_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .operand    (operand),
      .ins_value  (value_r),
      .prev_entry (prev_entry),
      .prev_valid (prev_valid),
      .prev_pre   (prev_pre),
      .prev_hit   (prev_hit),
      .next_entry (next_entry),
      .next_valid (next_valid),
      .entry      (entry_w[i]),
      .valid      (valid_w[i]),
      .pre_out    (pre_w[i]),
      .hit        (hit_w[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, ecount_r};
  assign out_tuser  = status_r;

endmodule

@@ sv/olist_cell.sv @@
// ----------------------------------------------------------------------------
// olist_cell: one slot of the ordered list
// holds one entry and its valid bit, a match flag and a match-before flag
// that travels one cell per cycle; shifts entries with its neighbors
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  olist_pkg::cell_ctrl_t          ctrl,
  input  logic [olist_pkg::DATA_W-1:0]   operand,
  input  logic [olist_pkg::DATA_W-1:0]   ins_value,
  input  logic [olist_pkg::DATA_W-1:0]   prev_entry,
  input  logic                           prev_valid,
  input  logic                           prev_pre,
  input  logic                           prev_hit,
  input  logic [olist_pkg::DATA_W-1:0]   next_entry,
  input  logic                           next_valid,
  output logic [olist_pkg::DATA_W-1:0]   entry,
  output logic                           valid,
  output logic                           pre_out,
  output logic                           hit
);
  import olist_pkg::*;

  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic              valid_r, valid_nxt;
  logic              match_r, match_nxt;
  logic              pre_r, pre_nxt;

  assign entry   = entry_r;
  assign valid   = valid_r;
  assign hit     = match_r & ~pre_r;
  assign pre_out = pre_r | match_r;

  always_comb begin
    match_nxt = match_r;
    pre_nxt   = pre_r;
    if (ctrl.load) begin
      match_nxt = valid_r & (entry_r == operand);
      pre_nxt   = 1'b0;
    end else if (ctrl.scan) begin
      pre_nxt = prev_pre;
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.apply) begin
      unique case (ctrl.kind)
        KD_PREPEND: begin
          entry_nxt = prev_entry;
          valid_nxt = prev_valid;
        end
        KD_APPEND: begin
          if (prev_valid & ~valid_r) begin
            entry_nxt = ins_value;
            valid_nxt = 1'b1;
          end
        end
        KD_INS_AFTER: begin
          if (pre_r) begin
            entry_nxt = prev_hit ? ins_value : prev_entry;
            valid_nxt = prev_valid;
          end
        end
        KD_INS_BEFORE: begin
          if (hit) begin
            entry_nxt = ins_value;
            valid_nxt = prev_valid;
          end else if (pre_r) begin
            entry_nxt = prev_entry;
            valid_nxt = prev_valid;
          end
        end
        KD_DELETE: begin
          if (hit | pre_r) begin
            entry_nxt = next_entry;
            valid_nxt = next_valid;
          end
        end
        default: begin
          entry_nxt = entry_r;
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      pre_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
      pre_r   <= pre_nxt;
    end
  end

endmodule
